// ===== hw/rtl/tphc_pkg.sv =====
// Package for the temperature, pressure and humidity compensation block.
// Holds the arithmetic helpers, register indexes and the queue entry type.
package tphc_pkg;

  localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
  localparam logic [2:0] REG_CAL_PRESS_C = 3'd3;
  localparam logic [2:0] REG_CAL_HUM_A   = 3'd4;
  localparam logic [2:0] REG_CAL_HUM_B   = 3'd5;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] num;
    logic [31:0] den;
    logic        neg_path;
    logic        dz;
    logic [31:0] hv;
  } tphc_item_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        dz;
    logic [16:0] hum;
  } tphc_res_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int s);
    asr = 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    mul = p[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    sx16 = {{16{x[15]}}, x};
  endfunction

endpackage

// ===== hw/rtl/tphc_front.sv =====
// Front part: computes the fine temperature, the pressure operands and
// the humidity value over registered stages. Depends on tphc_pkg.
module tphc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [19:0]       raw_temp,
  input  logic [19:0]       raw_press,
  input  logic [15:0]       raw_hum,
  input  logic [47:0]       cal_temp,
  input  logic [47:0]       cal_press_a,
  input  logic [47:0]       cal_press_b,
  input  logic [31:0]       cal_hum_a,
  input  logic [31:0]       cal_hum_b,
  output logic              out_valid,
  output tphc_pkg::tphc_item_t out_item
);
  import tphc_pkg::*;

  localparam int NS = 8;

  logic [NS-1:0] vld;
  logic [31:0] s1_a, s1_dd, s2_fine, s1_ap, s1_ah;
  logic [31:0] s2_ap, s2_ah, s3_fine, s3_ap, s3_ah, s3_sq, s3_pa, s3_v;
  logic [31:0] s4_fine, s4_ap, s4_ah, s4_b, s4_a, s4_v, s4_hb, s4_v_orig;
  logic [31:0] s5_fine, s5_num, s5_pa1, s5_ha, s5_hb;
  logic [31:0] s6_temp, s6_num, s6_den, s6_ha, s6_hb;
  logic [31:0] s7_temp, s7_num, s7_den, s7_hv;
  logic [31:0] s8_temp, s8_num, s8_den, s8_hv, s8_sq;
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, cal_temp[15:0]};
  assign t2 = sx16(cal_temp[31:16]);
  assign t3 = sx16(cal_temp[47:32]);
  assign p1 = {16'd0, cal_press_a[15:0]};
  assign p2 = sx16(cal_press_a[31:16]);
  assign p3 = sx16(cal_press_a[47:32]);
  assign p4 = sx16(cal_press_b[15:0]);
  assign p5 = sx16(cal_press_b[31:16]);
  assign p6 = sx16(cal_press_b[47:32]);
  assign h1 = {24'd0, cal_hum_a[7:0]};
  assign h2 = sx16(cal_hum_a[23:8]);
  assign h3 = {24'd0, cal_hum_a[31:24]};
  assign h4 = {{20{cal_hum_b[11]}}, cal_hum_b[11:0]};
  assign h5 = {{20{cal_hum_b[23]}}, cal_hum_b[23:12]};
  assign h6 = {{24{cal_hum_b[31]}}, cal_hum_b[31:24]};

  logic [31:0] d0, a0, pa_c, hv_c;
  assign d0 = {16'd0, raw_temp[19:4]} - t1;
  assign a0 = ({15'd0, raw_temp[19:3]} - (t1 << 1));
  assign pa_c = asr(s2_fine, 1) - 32'd64000;
  assign hv_c = s2_fine - 32'd76800;

  logic [31:0] hb1, hd1, sqd, hvv;
  assign hb1 = asr(s4_hb, 10);
  assign hd1 = asr(s4_v, 11) + 32'd32768;
  assign sqd = asr(s7_hv, 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a <= asr(mul(a0, t2), 11);
      s1_dd <= asr(mul(d0, d0), 12);
      s1_ap <= {12'd0, raw_press};
      s1_ah <= {16'd0, raw_hum};
      s2_fine <= s1_a + asr(mul(s1_dd, t3), 14);
      s2_ap <= s1_ap;
      s2_ah <= s1_ah;
      s3_fine <= s2_fine;
      s3_pa <= pa_c;
      s3_sq <= mul(asr(pa_c, 2), asr(pa_c, 2));
      s3_v <= hv_c;
      s3_ap <= s2_ap;
      s3_ah <= s2_ah;
      s4_fine <= s3_fine;
      s4_ap <= s3_ap;
      s4_ah <= s3_ah;
      s4_b <= asr(mul(asr(s3_sq, 11), p6) + (mul(s3_pa, p5) << 1), 2) + (p4 << 16);
      s4_a <= asr(asr(mul(p3, asr(s3_sq, 13)), 3) + asr(mul(p2, s3_pa), 1), 18);
      s4_v <= mul(s3_v, h3);
      s4_hb <= mul(s3_v, h6);
      s4_v_orig <= s3_v;
      s5_ha <= asr(((s4_ah << 14) - (h4 << 20) - mul(h5, s4_v_orig)) + 32'd16384, 15);
      s5_fine <= s4_fine;
      s5_num <= mul((32'd1048576 - s4_ap) - asr(s4_b, 12), 32'd3125);
      s5_pa1 <= asr(mul(32'd32768 + s4_a, p1), 15);
      s5_hb <= asr(mul(hb1, hd1), 10) + 32'd2097152;
      s6_temp <= asr(mul(s5_fine, 32'd5) + 32'd128, 8);
      s6_num <= s5_num;
      s6_den <= s5_pa1;
      s6_ha <= s5_ha;
      s6_hb <= asr(mul(s5_hb, h2) + 32'd8192, 14);
      s7_temp <= s6_temp;
      s7_num <= s6_num;
      s7_den <= s6_den;
      s7_hv <= mul(s6_ha, s6_hb);
      s8_temp <= s7_temp;
      s8_num <= s7_num;
      s8_den <= s7_den;
      s8_hv <= s7_hv;
      s8_sq <= asr(mul(sqd, sqd), 7);
    end
  end

  assign hvv = s8_hv - asr(mul(s8_sq, h1), 4);

  assign out_valid = vld[NS-1];
  always_comb begin
    out_item.temp = s8_temp;
    out_item.num = s8_num;
    out_item.den = s8_den;
    out_item.neg_path = s8_num[31];
    out_item.dz = (s8_den == 32'd0);
    out_item.hv = hvv;
  end
endmodule

// ===== hw/rtl/tphc_queue.sv =====
// Short queue between the front and back parts.
// Depends on tphc_pkg for the entry type.
module tphc_queue #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  tphc_pkg::tphc_item_t wdata,
  input  logic                 rd,
  output tphc_pkg::tphc_item_t rdata,
  output logic                 empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import tphc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  tphc_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (($clog2(DEPTH+1))'(wr)) - (($clog2(DEPTH+1))'(rd));
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  assign rdata = mem[rp];
  assign empty = (count == '0);
endmodule

// ===== hw/rtl/tphc_back.sv =====
// Back part: pipelined restoring divider and final pressure correction,
// humidity clamp, and an output register. Depends on tphc_pkg.
module tphc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  tphc_pkg::tphc_item_t in_item,
  input  logic [47:0]          cal_press_c,
  output logic                 out_valid,
  output tphc_pkg::tphc_res_t  out_res
);
  import tphc_pkg::*;

  localparam int NB = 32;
  localparam int NS = NB + 3;

  logic [NS-1:0] vld;
  logic [31:0] q [NB+1];
  logic [31:0] r [NB+1];
  logic [31:0] n [NB+1];
  logic [31:0] dv [NB+1];
  logic [31:0] tp [NB+1];
  logic [16:0] hm [NB+1];
  logic        ng [NB+1];
  logic        zz [NB+1];
  logic [31:0] p7, p8, p9;

  assign p7 = sx16(cal_press_c[15:0]);
  assign p8 = sx16(cal_press_c[31:16]);
  assign p9 = sx16(cal_press_c[47:32]);

  logic [31:0] hcl;
  always_comb begin
    hcl = in_item.hv;
    if (hcl[31]) hcl = '0;
    if (hcl > HUM_MAX) hcl = HUM_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n[0] <= in_item.neg_path ? in_item.num : (in_item.num << 1);
      dv[0] <= in_item.den;
      q[0] <= '0;
      r[0] <= '0;
      tp[0] <= in_item.temp;
      hm[0] <= hcl[28:12];
      ng[0] <= in_item.neg_path;
      zz[0] <= in_item.dz;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_div
    logic [32:0] rs;
    assign rs = {r[i], n[i][NB-1-i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rs >= {1'b0, dv[i]}) begin
          r[i+1] <= 32'(rs - {1'b0, dv[i]});
          q[i+1] <= q[i] | (32'd1 << (NB-1-i));
        end else begin
          r[i+1] <= rs[31:0];
          q[i+1] <= q[i];
        end
        n[i+1] <= n[i];
        dv[i+1] <= dv[i];
        tp[i+1] <= tp[i];
        hm[i+1] <= hm[i];
        ng[i+1] <= ng[i];
        zz[i+1] <= zz[i];
      end
    end
  end

  logic [31:0] pq, fa, fb;
  logic [31:0] s1_p, s1_a, s1_b, s1_t;
  logic [16:0] s1_h;
  logic        s1_z;
  assign pq = ng[NB] ? (q[NB] << 1) : q[NB];
  assign fa = mul(pq >> 3, pq >> 3) >> 13;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p <= pq;
      s1_a <= fa;
      s1_b <= asr(mul(pq >> 2, p8), 13);
      s1_t <= tp[NB];
      s1_h <= hm[NB];
      s1_z <= zz[NB];
      out_res.temp <= s1_t;
      out_res.hum <= s1_h;
      out_res.dz <= s1_z;
      out_res.press <= s1_z ? 32'd0 :
        s1_p + asr(asr(mul(p9, s1_a), 12) + s1_b + p7, 4);
    end
  end

  assign out_valid = vld[NS-1];
endmodule

// ===== hw/rtl/temp_press_hum_compensation_top.sv =====
// Top level of the temperature, pressure and humidity compensation block.
// Depends on tphc_pkg, tphc_front, tphc_queue and tphc_back.
//
// One sample set is accepted per clock while the queue has room. A result
// passes through the front pipeline, the queue and the back part, whose
// length is set by the one-bit-per-stage 32-bit divider for pressure. The
// front pipeline always advances and the back part advances only when not
// stalled; the queue between them absorbs what the front still holds when the
// output side stalls, and the input is refused while the queue lacks room.
module temp_press_hum_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // raw_temp, raw_press, raw_hum
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // temp_centi, press_pa, hum_q10, zero pad
  output logic        m_axis_tuser,   // press_div_zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import tphc_pkg::*;

  localparam int QD = 16;
  localparam int CW = $clog2(QD+1);

  logic [47:0] cal_temp, cal_press_a, cal_press_b, cal_press_c;
  logic [31:0] cal_hum_a, cal_hum_b;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp <= '0; cal_press_a <= '0; cal_press_b <= '0;
      cal_press_c <= '0; cal_hum_a <= '0; cal_hum_b <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAL_TEMP:    cal_temp <= cfg_data;
        REG_CAL_PRESS_A: cal_press_a <= cfg_data;
        REG_CAL_PRESS_B: cal_press_b <= cfg_data;
        REG_CAL_PRESS_C: cal_press_c <= cfg_data;
        REG_CAL_HUM_A:   cal_hum_a <= cfg_data[31:0];
        REG_CAL_HUM_B:   cal_hum_b <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic f_valid, q_empty, q_rd, b_en, b_valid;
  logic [CW-1:0] q_count;
  tphc_item_t f_item, q_item;
  tphc_res_t  b_res;

  // Everything in flight in the back part must fit the output stage, so the
  // back part advances only when its final register is free or being taken.
  assign b_en = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tvalid = b_valid;
  assign s_axis_tready = (q_count <= CW'(QD - 9));
  assign q_rd = b_en && !q_empty;

  tphc_front u_front (
    .clk, .rst, .en(1'b1),
    .in_valid(s_axis_tvalid && s_axis_tready),
    .raw_temp(s_axis_tdata[19:0]), .raw_press(s_axis_tdata[39:20]),
    .raw_hum(s_axis_tdata[55:40]),
    .cal_temp, .cal_press_a, .cal_press_b, .cal_hum_a, .cal_hum_b,
    .out_valid(f_valid), .out_item(f_item)
  );

  tphc_queue #(.DEPTH(QD)) u_queue (
    .clk, .rst, .wr(f_valid), .wdata(f_item), .rd(q_rd),
    .rdata(q_item), .empty(q_empty), .count(q_count)
  );

  tphc_back u_back (
    .clk, .rst, .en(b_en), .in_valid(q_rd), .in_item(q_item),
    .cal_press_c, .out_valid(b_valid), .out_res(b_res)
  );

  assign m_axis_tdata = {7'd0, b_res.hum, b_res.press, b_res.temp};
  assign m_axis_tuser = b_res.dz;

  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QD)) else $error("queue overflow");
  a_q_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_rd) else $error("queue underflow");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:32] == 32'd0))
    else $error("pressure not zero on divisor fault");
endmodule

// ===== sim/temp_press_hum_compensation_top_tb.sv =====
// Testbench for temp_press_hum_compensation_top: streams raw sample sets,
// predicts each compensated result in a local model and compares them.
// Depends on tphc_pkg for register indexes.
`timescale 1ns / 100ps

module temp_press_hum_compensation_top_tb;
  import tphc_pkg::*;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_pa;
    logic [16:0] hum_q10;
    logic        div_zero;
  } comp_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  logic [47:0] cal [0:5];
  logic [55:0] sample_queue [$];
  comp_result_t expected_results [$];
  int   errors;
  int   cycles;
  bit   hold_out;
  bit   drain_mode;
  int   out_gap;
  int   in_gap;

  temp_press_hum_compensation_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sar(input logic [31:0] x, input int s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] wmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic logic [31:0] sgn(input logic [47:0] x, input int w);
    logic [31:0] m;
    logic [31:0] sb;
    m = (32'd1 << w) - 32'd1;
    if (w == 32) m = 32'hFFFFFFFF;
    sb = 32'd1 << (w - 1);
    return ((x[31:0] & m) ^ sb) - sb;
  endfunction

  function automatic comp_result_t compensate(input logic [55:0] s);
    logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, a, b, d, fine, pr, v, sq;
    comp_result_t r;
    at = {12'd0, s[19:0]};
    ap = {12'd0, s[39:20]};
    ah = {16'd0, s[55:40]};
    t1 = {16'd0, cal[0][15:0]};
    t2 = sgn(cal[0] >> 16, 16);
    t3 = sgn(cal[0] >> 32, 16);
    p1 = {16'd0, cal[1][15:0]};
    p2 = sgn(cal[1] >> 16, 16);
    p3 = sgn(cal[1] >> 32, 16);
    p4 = sgn(cal[2], 16);
    p5 = sgn(cal[2] >> 16, 16);
    p6 = sgn(cal[2] >> 32, 16);
    p7 = sgn(cal[3], 16);
    p8 = sgn(cal[3] >> 16, 16);
    p9 = sgn(cal[3] >> 32, 16);
    h1 = {24'd0, cal[4][7:0]};
    h2 = sgn(cal[4] >> 8, 16);
    h3 = {24'd0, cal[4][31:24]};
    h4 = sgn(cal[5], 12);
    h5 = sgn(cal[5] >> 12, 12);
    h6 = sgn(cal[5] >> 24, 8);

    a = sar(wmul((at >> 3) - (t1 << 1), t2), 11);
    d = (at >> 4) - t1;
    b = sar(wmul(sar(wmul(d, d), 12), t3), 14);
    fine = a + b;
    r.temp_centi = sar(wmul(fine, 32'd5) + 32'd128, 8);

    a = sar(fine, 1) - 32'd64000;
    sq = wmul(sar(a, 2), sar(a, 2));
    b = wmul(sar(sq, 11), p6);
    b = b + (wmul(a, p5) << 1);
    b = sar(b, 2) + (p4 << 16);
    a = sar(sar(wmul(p3, sar(sq, 13)), 3) + sar(wmul(p2, a), 1), 18);
    a = sar(wmul(32'd32768 + a, p1), 15);
    r.div_zero = (a == 32'd0);
    if (r.div_zero) begin
      pr = 32'd0;
    end else begin
      pr = wmul((32'd1048576 - ap) - sar(b, 12), 32'd3125);
      if (pr < 32'h80000000) pr = (pr << 1) / a;
      else pr = (pr / a) * 32'd2;
      a = sar(wmul(p9, wmul(pr >> 3, pr >> 3) >> 13), 12);
      b = sar(wmul(pr >> 2, p8), 13);
      pr = pr + sar(a + b + p7, 4);
    end
    r.press_pa = pr;

    v = fine - 32'd76800;
    a = sar(((ah << 14) - (h4 << 20) - wmul(h5, v)) + 32'd16384, 15);
    b = sar(wmul(v, h6), 10);
    d = sar(wmul(v, h3), 11) + 32'd32768;
    b = sar(wmul(b, d), 10) + 32'd2097152;
    b = sar(wmul(b, h2) + 32'd8192, 14);
    v = wmul(a, b);
    d = sar(v, 15);
    v = v - sar(wmul(sar(wmul(d, d), 7), h1), 4);
    if (v[31]) v = 32'd0;
    if (v > 32'd419430400) v = 32'd419430400;
    v = v >> 12;
    r.hum_q10 = v[16:0];
    return r;
  endfunction

  // Input side: a sample leaves the queue when its transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(compensate(s_axis_tdata));
        void'(sample_queue.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0 && !drain_mode) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_queue[0];
        if ($urandom_range(0, 3) == 0)
          in_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    comp_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== want.temp_centi)
            $display("%0t: temp_centi expected %h actual %h", $time, want.temp_centi,
                     m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] !== want.press_pa)
            $display("%0t: press_pa expected %h actual %h", $time, want.press_pa,
                     m_axis_tdata[63:32]);
          if (m_axis_tdata[80:64] !== want.hum_q10)
            $display("%0t: hum_q10 expected %h actual %h", $time, want.hum_q10,
                     m_axis_tdata[80:64]);
          if (m_axis_tuser !== want.div_zero)
            $display("%0t: press_div_zero expected %b actual %b", $time, want.div_zero,
                     m_axis_tuser);
          if (m_axis_tdata[31:0] !== want.temp_centi || m_axis_tdata[63:32] !== want.press_pa
              || m_axis_tdata[80:64] !== want.hum_q10 || m_axis_tuser !== want.div_zero)
            errors++;
        end
      end
      if (hold_out) begin
        m_axis_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          out_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("temp_press_hum_compensation_top: mismatch");
      $finish;
    end
  end

  task automatic write_cal(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cal[idx] = (idx >= REG_CAL_HUM_A) ? {16'd0, val[31:0]} : val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (sample_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [55:0] rand_sample();
    logic [55:0] s;
    s[19:0] = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(400000, 600000));
    s[39:20] = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(250000, 450000));
    s[55:40] = 16'($urandom);
    return s;
  endfunction

  task automatic typical_cal();
    write_cal(REG_CAL_TEMP, {16'hFE18, 16'h6A8D, 16'h6FE0});
    write_cal(REG_CAL_PRESS_A, {16'h0BD0, 16'hD666, 16'h8E7B});
    write_cal(REG_CAL_PRESS_B, {16'hFFF9, 16'hFF1C, 16'h1E9D});
    write_cal(REG_CAL_PRESS_C, {16'h1770, 16'hD4A0, 16'h008C});
    write_cal(REG_CAL_HUM_A, {8'h00, 16'h0169, 8'h4B});
    write_cal(REG_CAL_HUM_B, {8'h1E, 12'h032, 12'h149});
  endtask

  task automatic random_cal();
    for (int i = 0; i < 6; i++)
      write_cal(3'(i), 48'({$urandom, $urandom}));
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_out = 1'b0;
    drain_mode = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 6; i++) cal[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration gives a zero divisor; then extremes under typical calibration.
    sample_queue.push_back(56'd0);
    sample_queue.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
    wait_idle();
    typical_cal();
    sample_queue.push_back({16'h0000, 20'h00000, 20'h00000});
    sample_queue.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
    sample_queue.push_back({16'h0000, 20'hFFFFF, 20'h00000});
    sample_queue.push_back({16'hFFFF, 20'h00000, 20'hFFFFF});
    sample_queue.push_back({16'h6A5C, 20'h5A3C0, 20'h7E7B0});
    sample_queue.push_back({16'hAAAA, 20'hAAAAA, 20'h55555});
    sample_queue.push_back({16'h5555, 20'h55555, 20'hAAAAA});
    wait_idle();
    // Extreme calibration words, all ones and sign bits only.
    for (int i = 0; i < 6; i++) write_cal(3'(i), 48'hFFFFFFFFFFFF);
    for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample());
    wait_idle();
    for (int i = 0; i < 6; i++) write_cal(3'(i), 48'h800080008000);
    for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample());
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 3 == 2) random_cal();
      else typical_cal();
      if (phase == 3) write_cal(REG_CAL_PRESS_A, 48'h0);
      for (int i = 0; i < 235; i++) sample_queue.push_back(rand_sample());
      if (phase == 1) begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      if (phase == 4) begin
        while (sample_queue.size() > 120) @(posedge clk);
        drain_mode = 1'b1;
        while (s_axis_tvalid || expected_results.size() > 0) @(posedge clk);
        drain_mode = 1'b0;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("temp_press_hum_compensation_top: match");
    end else begin
      $display("temp_press_hum_compensation_top: mismatch");
    end
    $finish;
  end
endmodule
